>>> design/i2ct_pkg.sv
// ----------------------------------------------------------------------------
// i2ct_pkg: shared types and constants for the I2C target register core
// Phase codes, per-request state and per-request result structures.
// ----------------------------------------------------------------------------
package i2ct_pkg;

   localparam logic [6:0] OwnAddressReset = 7'h39;

   typedef enum logic [8:0] {
      PH_IDLE        = 9'b0_0000_0001,
      PH_START       = 9'b0_0000_0010,
      PH_ADDR_WR_ACK = 9'b0_0000_0100,
      PH_ADDR_RD_ACK = 9'b0_0000_1000,
      PH_WRITE_REG   = 9'b0_0001_0000,
      PH_WRITE       = 9'b0_0010_0000,
      PH_WRITE_ACK   = 9'b0_0100_0000,
      PH_READ        = 9'b0_1000_0000,
      PH_READ_ACK    = 9'b1_0000_0000
   } phase_type;

   localparam logic OpStart    = 1'b0;
   localparam logic OpOverflow = 1'b1;

   typedef struct packed {
      phase_type  phase;
      logic [7:0] pointer;
      logic       sda_enabled;
   } state_type;

   typedef struct packed {
      logic       sda_drive;
      logic       tx_load;
      logic [7:0] tx_byte;
      logic       one_bit_phase;
      logic       reg_write;
      logic [7:0] target_reg;
      logic [7:0] write_value;
      logic       reg_read;
      logic       activity;
      logic       idle;
   } result_type;

endpackage

>>> design/i2ct_step.sv
// ----------------------------------------------------------------------------
// i2ct_step: protocol step for one event
// Next phase, pointer and SDA enable plus the result fields for one request.
// ----------------------------------------------------------------------------
module i2ct_step (
   input  i2ct_pkg::state_type  state_cur,
   input  logic                 op,
   input  logic                 scl_went_low,
   input  logic [7:0]           rx_shift,
   input  logic [7:0]           reg_value,
   input  logic [6:0]           own_address,
   output i2ct_pkg::state_type  state_nxt,
   output i2ct_pkg::result_type result
);
   import i2ct_pkg::*;

   logic ack_load;
   logic data_load;
   state_type  st;
   result_type res;

   always_comb begin
      st        = state_cur;
      res       = '0;
      ack_load  = 1'b0;
      data_load = 1'b0;
      if (op == OpStart) begin
         st.sda_enabled = 1'b0;
         st.phase       = scl_went_low ? PH_START : PH_IDLE;
      end else begin
         case (state_cur.phase)
            PH_START: begin
               if (rx_shift[7:1] == own_address) begin
                  st.phase = rx_shift[0] ? PH_ADDR_RD_ACK : PH_ADDR_WR_ACK;
                  ack_load = 1'b1;
               end else begin
                  st.phase = PH_IDLE;
               end
            end
            PH_ADDR_WR_ACK: begin
               st.sda_enabled = 1'b0;
               st.phase       = PH_WRITE_REG;
            end
            PH_WRITE_ACK: begin
               st.sda_enabled = 1'b0;
               st.phase       = PH_WRITE;
            end
            PH_WRITE_REG: begin
               st.pointer     = rx_shift;
               res.activity   = 1'b1;
               res.target_reg = rx_shift;
               st.phase       = PH_WRITE_ACK;
               ack_load       = 1'b1;
            end
            PH_WRITE: begin
               res.reg_write   = 1'b1;
               res.target_reg  = state_cur.pointer;
               res.write_value = rx_shift;
               st.pointer      = state_cur.pointer + 8'd1;
               st.phase        = PH_WRITE_ACK;
               ack_load        = 1'b1;
            end
            PH_ADDR_RD_ACK: begin
               data_load = 1'b1;
            end
            PH_READ: begin
               st.sda_enabled    = 1'b0;
               st.phase          = PH_READ_ACK;
               res.one_bit_phase = 1'b1;
            end
            PH_READ_ACK: begin
               if (rx_shift[0]) begin
                  st.phase = PH_IDLE;
               end else begin
                  data_load = 1'b1;
               end
            end
            default: begin
               st.phase = PH_IDLE;
            end
         endcase
         if (ack_load) begin
            res.tx_load       = 1'b1;
            res.tx_byte       = 8'd0;
            st.sda_enabled    = 1'b1;
            res.one_bit_phase = 1'b1;
         end
         // read data goes out at the pointer, pointer advances
         if (data_load) begin
            res.tx_load       = 1'b1;
            res.tx_byte       = reg_value;
            res.reg_read      = 1'b1;
            res.target_reg    = state_cur.pointer;
            st.pointer        = state_cur.pointer + 8'd1;
            st.sda_enabled    = 1'b1;
            st.phase          = PH_READ;
            res.one_bit_phase = 1'b0;
         end
      end
      res.sda_drive = st.sda_enabled;
      res.idle      = (st.phase == PH_IDLE);
   end

   assign state_nxt = st;
   assign result    = res;

endmodule

>>> design/i2c_target_register_access_core.sv
// ----------------------------------------------------------------------------
// i2c_target_register_access_core: byte-level I2C target with register pointer
// Takes start and shift-counter overflow events, returns one response each.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one request per shift-unit event (start or counter overflow),
//            carrying the received shift byte and the register at the pointer.
//   rsp_*  : one response per request: SDA drive, byte to load, counter mode,
//            register read/write pulses, activity and idle status.
//   csr_*  : write of own_address; always ready, write only while idle.
// The response to an accepted request is registered and shows in the cycle
// after acceptance. Throughput is one request per cycle while responses are
// taken, set by the single response register that follows the protocol step logic.
// While the response waits, req_ready stays high only if rsp_ready is high
// in the same cycle; a stalled response holds and blocks new requests.
// Reset (synchronous) puts the phase in idle, the pointer at zero, SDA
// released, own_address at 0x39 and no response pending.
// ----------------------------------------------------------------------------
module i2c_target_register_access_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_op,
   input  logic       req_scl_went_low,
   input  logic [7:0] req_rx_shift,
   input  logic [7:0] req_reg_value,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_sda_drive,
   output logic       rsp_tx_load,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_one_bit_phase,
   output logic       rsp_reg_write,
   output logic [7:0] rsp_target_reg,
   output logic [7:0] rsp_write_value,
   output logic       rsp_reg_read,
   output logic       rsp_activity,
   output logic       rsp_idle,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [6:0] csr_own_address
);
   import i2ct_pkg::*;

   state_type  state_ff;
   state_type  state_in;
   result_type result_ff;
   result_type result_in;
   logic       rsp_valid_ff;
   logic [6:0] own_address_ff;
   logic       req_accept;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   i2ct_step u_step (
      .state_cur    (state_ff),
      .op           (req_op),
      .scl_went_low (req_scl_went_low),
      .rx_shift     (req_rx_shift),
      .reg_value    (req_reg_value),
      .own_address  (own_address_ff),
      .state_nxt    (state_in),
      .result       (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase       <= PH_IDLE;
         state_ff.pointer     <= 8'd0;
         state_ff.sda_enabled <= 1'b0;
         rsp_valid_ff         <= 1'b0;
         own_address_ff       <= OwnAddressReset;
      end else begin
         if (req_accept) begin
            state_ff <= state_in;
         end
         if (req_accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            own_address_ff <= csr_own_address;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sda_drive     = result_ff.sda_drive;
   assign rsp_tx_load       = result_ff.tx_load;
   assign rsp_tx_byte       = result_ff.tx_byte;
   assign rsp_one_bit_phase = result_ff.one_bit_phase;
   assign rsp_reg_write     = result_ff.reg_write;
   assign rsp_target_reg    = result_ff.target_reg;
   assign rsp_write_value   = result_ff.write_value;
   assign rsp_reg_read      = result_ff.reg_read;
   assign rsp_activity      = result_ff.activity;
   assign rsp_idle          = result_ff.idle;

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: regression for the I2C target register access core
// Drives start and shift-counter overflow requests as write transfers, read
// transfers, cut-off transfers and line noise, under several own_address
// settings and several patterns of sender gaps and receiver stalls. Each
// response is checked field by field against a protocol predictor that is
// updated as each request is accepted.
// ----------------------------------------------------------------------------
module tb;
   import i2ct_pkg::*;

   localparam int CycleLimit  = 300000;
   localparam int PhaseItems  = 250;

   class i2c_target_scoreboard;
      phase_type  proto_phase;
      logic [7:0] reg_ptr;
      logic       sda_on;
      logic [6:0] own_addr;
      result_type expected_q[$];
      int         errors;

      function new();
         proto_phase = PH_IDLE;
         reg_ptr     = '0;
         sda_on      = 1'b0;
         own_addr    = OwnAddressReset;
         errors      = 0;
      endfunction

      function void set_address(logic [6:0] addr);
         own_addr = addr;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_request(logic op, logic scl_low, logic [7:0] rx, logic [7:0] rv);
         result_type r;
         logic       ack;
         logic       load_data;
         r         = '0;
         ack       = 1'b0;
         load_data = 1'b0;
         if (op == OpStart) begin
            sda_on      = 1'b0;
            proto_phase = scl_low ? PH_START : PH_IDLE;
         end else begin
            case (proto_phase)
               PH_START: begin
                  if (rx[7:1] == own_addr) begin
                     proto_phase = rx[0] ? PH_ADDR_RD_ACK : PH_ADDR_WR_ACK;
                     ack         = 1'b1;
                  end else begin
                     proto_phase = PH_IDLE;
                  end
               end
               PH_ADDR_WR_ACK: begin
                  sda_on      = 1'b0;
                  proto_phase = PH_WRITE_REG;
               end
               PH_WRITE_ACK: begin
                  sda_on      = 1'b0;
                  proto_phase = PH_WRITE;
               end
               PH_WRITE_REG: begin
                  reg_ptr      = rx;
                  r.activity   = 1'b1;
                  r.target_reg = rx;
                  proto_phase  = PH_WRITE_ACK;
                  ack          = 1'b1;
               end
               PH_WRITE: begin
                  r.reg_write   = 1'b1;
                  r.target_reg  = reg_ptr;
                  r.write_value = rx;
                  reg_ptr       = reg_ptr + 8'd1;
                  proto_phase   = PH_WRITE_ACK;
                  ack           = 1'b1;
               end
               PH_ADDR_RD_ACK: begin
                  load_data = 1'b1;
               end
               PH_READ: begin
                  sda_on          = 1'b0;
                  proto_phase     = PH_READ_ACK;
                  r.one_bit_phase = 1'b1;
               end
               PH_READ_ACK: begin
                  if (rx[0]) proto_phase = PH_IDLE;
                  else load_data = 1'b1;
               end
               default: begin
                  proto_phase = PH_IDLE;
               end
            endcase
            if (ack) begin
               r.tx_load       = 1'b1;
               r.tx_byte       = 8'h00;
               r.one_bit_phase = 1'b1;
               sda_on          = 1'b1;
            end
            if (load_data) begin
               r.tx_load       = 1'b1;
               r.tx_byte       = rv;
               r.reg_read      = 1'b1;
               r.target_reg    = reg_ptr;
               r.one_bit_phase = 1'b0;
               reg_ptr         = reg_ptr + 8'd1;
               sda_on          = 1'b1;
               proto_phase     = PH_READ;
            end
         end
         r.sda_drive = sda_on;
         r.idle      = (proto_phase == PH_IDLE);
         expected_q.push_back(r);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] seen);
         if (want !== seen) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, seen);
            errors++;
         end
      endfunction

      function void check_response(result_type got);
         result_type exp;
         if (expected_q.size() == 0) begin
            $display("%0t: response %h with nothing expected", $time, got);
            errors++;
            return;
         end
         exp = expected_q.pop_front();
         compare_field("sda_drive", 8'(exp.sda_drive), 8'(got.sda_drive));
         compare_field("tx_load", 8'(exp.tx_load), 8'(got.tx_load));
         compare_field("tx_byte", exp.tx_byte, got.tx_byte);
         compare_field("one_bit_phase", 8'(exp.one_bit_phase), 8'(got.one_bit_phase));
         compare_field("reg_write", 8'(exp.reg_write), 8'(got.reg_write));
         compare_field("target_reg", exp.target_reg, got.target_reg);
         compare_field("write_value", exp.write_value, got.write_value);
         compare_field("reg_read", 8'(exp.reg_read), 8'(got.reg_read));
         compare_field("activity", 8'(exp.activity), 8'(got.activity));
         compare_field("idle", 8'(exp.idle), 8'(got.idle));
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic       req_op;
   logic       req_scl_went_low;
   logic [7:0] req_rx_shift;
   logic [7:0] req_reg_value;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_sda_drive;
   logic       rsp_tx_load;
   logic [7:0] rsp_tx_byte;
   logic       rsp_one_bit_phase;
   logic       rsp_reg_write;
   logic [7:0] rsp_target_reg;
   logic [7:0] rsp_write_value;
   logic       rsp_reg_read;
   logic       rsp_activity;
   logic       rsp_idle;
   logic       csr_valid;
   logic       csr_ready;
   logic [6:0] csr_own_address;
   result_type rsp_seen;

   i2c_target_scoreboard sb = new();
   int tx_gap_pct   = 0;
   int rx_stall_pct = 0;
   int req_count    = 0;
   int cycle_count  = 0;
   bit noise_on     = 1'b0;

   i2c_target_register_access_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_scl_went_low  (req_scl_went_low),
      .req_rx_shift      (req_rx_shift),
      .req_reg_value     (req_reg_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sda_drive     (rsp_sda_drive),
      .rsp_tx_load       (rsp_tx_load),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_one_bit_phase (rsp_one_bit_phase),
      .rsp_reg_write     (rsp_reg_write),
      .rsp_target_reg    (rsp_target_reg),
      .rsp_write_value   (rsp_write_value),
      .rsp_reg_read      (rsp_reg_read),
      .rsp_activity      (rsp_activity),
      .rsp_idle          (rsp_idle),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_own_address   (csr_own_address)
   );

   assign rsp_seen = {rsp_sda_drive, rsp_tx_load, rsp_tx_byte, rsp_one_bit_phase,
                      rsp_reg_write, rsp_target_reg, rsp_write_value, rsp_reg_read,
                      rsp_activity, rsp_idle};

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_seen);
      rsp_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
   end

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_req(logic op, logic scl_low, logic [7:0] rx, logic [7:0] rv);
      while (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_op           <= op;
      req_scl_went_low <= scl_low;
      req_rx_shift     <= rx;
      req_reg_value    <= rv;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(op, scl_low, rx, rv);
      if (!noise_on) req_count++;
   endtask

   task automatic send_start(logic scl_low);
      send_req(OpStart, scl_low, rand_byte(), rand_byte());
   endtask

   task automatic send_overflow(logic [7:0] rx, logic [7:0] rv);
      send_req(OpOverflow, 1'($urandom_range(0, 1)), rx, rv);
   endtask

   // no request in flight afterwards
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_own_address(logic [6:0] addr);
      csr_valid       <= 1'b1;
      csr_own_address <= addr;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_address(addr);
      csr_valid <= 1'b0;
   endtask

   task automatic directed_checks();
      send_overflow(8'hFF, 8'hFF);          // overflow while idle
      send_start(1'b0);                     // start not confirmed
      send_overflow(8'h00, 8'h00);
      send_start(1'b1);
      send_overflow(8'h70, 8'h00);          // address mismatch
      send_start(1'b1);
      send_overflow(8'h72, 8'h00);          // write address
      send_overflow(8'hFF, 8'h00);
      send_overflow(8'hFF, 8'hFF);          // pointer at top, wraps next
      send_overflow(8'h00, 8'h00);
      send_overflow(8'h00, 8'hFF);
      send_overflow(8'hFF, 8'h00);
      send_overflow(8'hFF, 8'h00);
      send_overflow(8'h00, 8'h00);
      send_start(1'b1);                     // repeated start
      send_overflow(8'h73, 8'h00);          // read address
      send_overflow(8'h00, 8'hFF);
      send_overflow(8'hFF, 8'h00);
      send_overflow(8'hFE, 8'h00);          // controller ACK
      send_overflow(8'h00, 8'hFF);
      send_overflow(8'h01, 8'h00);          // controller NACK
      send_start(1'b1);
      send_overflow(8'h73, 8'h55);
      send_start(1'b0);                     // abort with SDA driven
      send_overflow(8'hAA, 8'h55);
   endtask

   task automatic write_transfer();
      logic [7:0] ptr;
      int         n;
      ptr = ($urandom_range(0, 3) == 0) ? 8'hFE + 8'($urandom_range(0, 2)) : rand_byte();
      n   = $urandom_range(0, 6);
      send_start(1'b1);
      send_overflow({sb.own_addr, 1'b0}, rand_byte());
      send_overflow(rand_byte(), rand_byte());
      send_overflow(ptr, rand_byte());
      send_overflow(rand_byte(), rand_byte());
      repeat (n) begin
         send_overflow(rand_byte(), rand_byte());
         send_overflow(rand_byte(), rand_byte());
      end
      if ($urandom_range(0, 3) == 0) send_start(1'b0);
   endtask

   task automatic read_transfer();
      int n;
      n = $urandom_range(1, 6);
      send_start(1'b1);
      send_overflow({sb.own_addr, 1'b1}, rand_byte());
      send_overflow(rand_byte(), rand_byte());
      for (int i = 1; i <= n; i++) begin
         send_overflow(rand_byte(), rand_byte());
         send_overflow({7'(rand_byte() >> 1), i == n}, rand_byte());
      end
   endtask

   task automatic broken_transfer();
      send_start($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1) == 0)
         send_overflow({sb.own_addr, 1'($urandom_range(0, 1))}, rand_byte());
      else send_overflow(rand_byte(), rand_byte());
      repeat ($urandom_range(0, 5)) send_overflow(rand_byte(), rand_byte());
   endtask

   task automatic line_noise();
      noise_on = 1'b1;
      repeat ($urandom_range(1, 4))
         send_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rand_byte(),
                  rand_byte());
      noise_on = 1'b0;
   endtask

   initial begin
      int         kind;
      bit         paused;
      logic [6:0] addr_pick;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_op           <= OpStart;
      req_scl_went_low <= 1'b0;
      req_rx_shift     <= 8'h00;
      req_reg_value    <= 8'h00;
      csr_valid        <= 1'b0;
      csr_own_address  <= 7'h00;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      directed_checks();
      for (int p = 0; p < 8; p++) begin
         drain_responses();
         if (p > 0) begin
            case (p)
               1:       addr_pick = 7'h00;
               2:       addr_pick = 7'h7F;
               3:       addr_pick = OwnAddressReset;
               default: addr_pick = 7'($urandom_range(0, 127));
            endcase
            write_own_address(addr_pick);
         end
         case (p % 4)
            0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_gap_pct = 49; rx_stall_pct = 0;  end
            2: begin tx_gap_pct = 0;  rx_stall_pct = 49; end
            default: begin tx_gap_pct = 35; rx_stall_pct = 35; end
         endcase
         req_count = 0;
         paused    = 1'b0;
         while (req_count < PhaseItems) begin
            if (!paused && req_count >= PhaseItems / 2) begin
               drain_responses();
               paused = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 40) write_transfer();
            else if (kind < 80) read_transfer();
            else if (kind < 92) broken_transfer();
            else line_noise();
         end
      end
      drain_responses();
      repeat (4) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
